@@ src/glu_pkg.sv @@
package glu_pkg;

   // fixed widths of the channel fields
   localparam int OPERAND_WIDTH = 32;
   localparam int GCD_WIDTH     = 32;
   localparam int LCM_WIDTH     = 64;

   typedef logic [OPERAND_WIDTH-1:0] operand_type;
   typedef logic [GCD_WIDTH-1:0]     gcd_type;
   typedef logic [LCM_WIDTH-1:0]     lcm_type;

   // divider status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ src/glu_divider.sv @@
// restoring divider, one quotient bit per cycle
module glu_divider #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DATA_WIDTH-1:0]    dividend,
   input  logic [DATA_WIDTH-1:0]    divisor,
   output logic [DATA_WIDTH-1:0]    quotient,
   output logic [DATA_WIDTH-1:0]    remainder,
   output glu_pkg::div_status_type  status
);

   localparam int CNT_W = $clog2(DATA_WIDTH + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] dvs_ff, dvs_in;
   logic [DATA_WIDTH:0]   rem_shift;
   logic [DATA_WIDTH:0]   rem_diff;

   assign rem_shift = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (busy_ff) begin
         // trial subtract, keep the difference when it does not borrow
         if (!rem_diff[DATA_WIDTH]) begin
            rem_in = rem_diff[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DATA_WIDTH);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

@@ src/gcd_lcm_unit_top.sv @@
// gcd and lcm of two unsigned operands. each request transfer carries operand_a and
// operand_b (only the low DATA_WIDTH bits count) and gives one response transfer with
// the greatest common divisor (1 when both operands are zero) and the least common
// multiple, formed as (a / gcd) * b at twice the operand width (0 when either operand
// is zero). one item is worked on at a time; a new request is taken as soon as the
// previous one has moved into the response register, even if that is still waiting.
// the divider is bit-serial and is used for one pass per euclid step (k steps, at most
// 46 for 32 bits) and one more pass for a / gcd, followed by a shift-and-add multiply
// over the DATA_WIDTH quotient bits
module gcd_lcm_unit_top #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [glu_pkg::OPERAND_WIDTH-1:0] req_operand_a,
   input  logic [glu_pkg::OPERAND_WIDTH-1:0] req_operand_b,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [glu_pkg::GCD_WIDTH-1:0] rsp_gcd_value,
   output logic [glu_pkg::LCM_WIDTH-1:0] rsp_lcm_value
);

   localparam int CNT_W = $clog2(DATA_WIDTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EUC_CHECK,
      ST_EUC_WAIT,
      ST_QUOT_START,
      ST_QUOT_WAIT,
      ST_MULT,
      ST_FINISH
   } state_type;

   state_type               state_ff, state_in;
   // euclid pair; x also holds the gcd once the loop ends
   logic [DATA_WIDTH-1:0]   x_ff, x_in;
   logic [DATA_WIDTH-1:0]   y_ff, y_in;
   logic [DATA_WIDTH-1:0]   a_ff, a_in;
   logic [DATA_WIDTH-1:0]   b_ff, b_in;
   // product shift register: hi accumulates, lo shifts the multiplier out
   logic [DATA_WIDTH-1:0]   hi_ff, hi_in;
   logic [DATA_WIDTH-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   glu_pkg::gcd_type        gcd_ff, gcd_in;
   glu_pkg::lcm_type        lcm_ff, lcm_in;

   logic                    div_start;
   logic [DATA_WIDTH-1:0]   div_dividend;
   logic [DATA_WIDTH-1:0]   div_divisor;
   logic [DATA_WIDTH-1:0]   div_quotient;
   logic [DATA_WIDTH-1:0]   div_remainder;
   glu_pkg::div_status_type div_status;
   logic [DATA_WIDTH:0]     mult_sum;

   // one divider serves both the euclid steps and the final a / gcd
   assign div_start    = ((state_ff == ST_EUC_CHECK) && (y_ff != '0))
                         || (state_ff == ST_QUOT_START);
   assign div_dividend = (state_ff == ST_QUOT_START) ? a_ff : x_ff;
   assign div_divisor  = (state_ff == ST_QUOT_START) ? x_ff : y_ff;

   glu_divider #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .status    (div_status)
   );

   // add b when the multiplier bit is set, then shift the whole product right
   assign mult_sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, b_ff} : '0);

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      cnt_in       = cnt_ff;
      gcd_in       = gcd_ff;
      lcm_in       = lcm_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               a_in     = req_operand_a[DATA_WIDTH-1:0];
               b_in     = req_operand_b[DATA_WIDTH-1:0];
               x_in     = req_operand_a[DATA_WIDTH-1:0];
               y_in     = req_operand_b[DATA_WIDTH-1:0];
               state_in = ST_EUC_CHECK;
            end
         end
         ST_EUC_CHECK: begin
            if (y_ff == '0) begin
               // loop finished; both operands zero gives gcd 1
               if (x_ff == '0) begin
                  x_in = DATA_WIDTH'(1);
               end
               state_in = ST_QUOT_START;
            end else begin
               state_in = ST_EUC_WAIT;
            end
         end
         ST_EUC_WAIT: begin
            if (div_status.done) begin
               x_in     = y_ff;
               y_in     = div_remainder;
               state_in = ST_EUC_CHECK;
            end
         end
         ST_QUOT_START: begin
            state_in = ST_QUOT_WAIT;
         end
         ST_QUOT_WAIT: begin
            if (div_status.done) begin
               hi_in    = '0;
               lo_in    = div_quotient;
               cnt_in   = CNT_W'(DATA_WIDTH);
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            hi_in  = mult_sum[DATA_WIDTH:1];
            lo_in  = {mult_sum[0], lo_ff[DATA_WIDTH-1:1]};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait for the response register to free up; x still holds the gcd
            if (!rsp_valid_ff || rsp_ready) begin
               gcd_in       = glu_pkg::gcd_type'(x_ff);
               lcm_in       = glu_pkg::lcm_type'({hi_ff, lo_ff});
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      gcd_ff <= gcd_in;
      lcm_ff <= lcm_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_gcd_value = gcd_ff;
   assign rsp_lcm_value = lcm_ff;

endmodule

@@ test/gcd_lcm_unit_top_test.sv @@
module gcd_lcm_unit_top_test;

   localparam int DATA_WIDTH = 32;
   // only the low DATA_WIDTH bits of each operand take part
   localparam glu_pkg::operand_type OPERAND_MASK =
      glu_pkg::operand_type'((64'd1 << DATA_WIDTH) - 64'd1);
   // receiver hold-off long enough for the block to fill and stall its input
   localparam int LONG_HOLD = 5000;
   // cycles with no transfer on either channel before the run is given up
   localparam int STALL_LIMIT = 20000;
   // settling time at the end, above the worst single-item latency
   localparam int DRAIN_CYCLES = 2000;

   typedef struct packed {
      glu_pkg::operand_type a;
      glu_pkg::operand_type b;
   } operand_pair_type;

   typedef struct packed {
      glu_pkg::gcd_type divisor;
      glu_pkg::lcm_type multiple;
   } gcd_lcm_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   glu_pkg::operand_type req_operand_a = '0;
   glu_pkg::operand_type req_operand_b = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   glu_pkg::gcd_type     rsp_gcd_value;
   glu_pkg::lcm_type     rsp_lcm_value;

   // operand pairs waiting to be offered, and results owed by the block
   operand_pair_type   operand_backlog[$];
   gcd_lcm_result_type gcd_lcm_due[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatch_count = 0;
   int stall_cycles = 0;
   // long receiver hold-offs asked for, and those already begun
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;

   gcd_lcm_unit_top #(
      .DATA_WIDTH(DATA_WIDTH)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_gcd_value(rsp_gcd_value),
      .rsp_lcm_value(rsp_lcm_value)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // euclid by repeated remainder, then lcm as (a / gcd) * b at double width
   function automatic gcd_lcm_result_type predict_gcd_lcm(glu_pkg::operand_type a_in,
                                                          glu_pkg::operand_type b_in);
      glu_pkg::operand_type a;
      glu_pkg::operand_type b;
      glu_pkg::operand_type x;
      glu_pkg::operand_type y;
      glu_pkg::operand_type r;
      gcd_lcm_result_type res;
      a = a_in & OPERAND_MASK;
      b = b_in & OPERAND_MASK;
      x = a;
      y = b;
      while (y != '0) begin
         r = x % y;
         x = y;
         y = r;
      end
      // both operands zero: gcd reported as one
      if (x == '0) x = glu_pkg::operand_type'(1);
      res.divisor = glu_pkg::gcd_type'(x);
      res.multiple = glu_pkg::lcm_type'(a / x) * glu_pkg::lcm_type'(b);
      return res;
   endfunction

   // random pair, mostly shaped towards interesting divisor structure
   function automatic operand_pair_type random_pair();
      operand_pair_type p;
      glu_pkg::operand_type common;
      int pick;
      pick = $urandom_range(9);
      case (pick)
         0, 1, 2, 3: begin
            p.a = $urandom;
            p.b = $urandom;
         end
         4, 5: begin
            // large shared factor
            common = $urandom_range(1, 65535);
            p.a = common * glu_pkg::operand_type'($urandom_range(1, 65535));
            p.b = common * glu_pkg::operand_type'($urandom_range(1, 65535));
         end
         6: begin
            p.a = $urandom_range(15);
            p.b = $urandom_range(15);
         end
         7: begin
            // one side at an extreme
            case ($urandom_range(2))
               0: common = '0;
               1: common = glu_pkg::operand_type'(1);
               default: common = '1;
            endcase
            if ($urandom_range(1) == 0) begin
               p.a = common;
               p.b = $urandom;
            end else begin
               p.a = $urandom;
               p.b = common;
            end
         end
         8: begin
            // powers of two times small odd numbers
            p.a = glu_pkg::operand_type'($urandom_range(1, 255) | 1) << $urandom_range(24);
            p.b = glu_pkg::operand_type'($urandom_range(1, 255) | 1) << $urandom_range(24);
         end
         default: begin
            // equal or neighbouring operands
            p.a = $urandom;
            p.b = p.a + glu_pkg::operand_type'($urandom_range(3));
         end
      endcase
      return p;
   endfunction

   task automatic queue_random(int count);
      repeat (count) operand_backlog.push_back(random_pair());
   endtask

   // sender pause: nothing queued, nothing on offer, nothing owed
   task automatic wait_drained();
      while (operand_backlog.size() != 0 || req_valid || gcd_lcm_due.size() != 0)
         @(negedge clock);
   endtask

   // request driver: predicts on each accepted transfer, then offers the next pair
   always @(posedge clock) begin : request_driver
      operand_pair_type next_pair;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            gcd_lcm_due.push_back(predict_gcd_lcm(req_operand_a, req_operand_b));
         // a new pair only once the current one has gone, so valid never drops early
         if (!req_valid || req_ready) begin
            if (operand_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_pair = operand_backlog.pop_front();
               req_valid <= 1'b1;
               req_operand_a <= next_pair.a;
               req_operand_b <= next_pair.b;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: checks each transfer against the oldest owed result
   always @(posedge clock) begin : response_monitor
      gcd_lcm_result_type owed;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (gcd_lcm_due.size() == 0) begin
               $display("%0t: response with nothing owed, gcd %0d lcm %0d",
                        $time, rsp_gcd_value, rsp_lcm_value);
               mismatch_count++;
            end else begin
               owed = gcd_lcm_due.pop_front();
               if (rsp_gcd_value !== owed.divisor) begin
                  $display("%0t: gcd mismatch, expected %0d, got %0d",
                           $time, owed.divisor, rsp_gcd_value);
                  mismatch_count++;
               end
               if (rsp_lcm_value !== owed.multiple) begin
                  $display("%0t: lcm mismatch, expected %0d, got %0d",
                           $time, owed.multiple, rsp_lcm_value);
                  mismatch_count++;
               end
            end
         end
         // long hold-off counted here, otherwise random back-pressure
         if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left <= LONG_HOLD;
            rsp_ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("gcd_lcm_unit_top_test: done, errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part under light sender idling and heavy receiver idling
      send_idle_pct = 25;
      recv_idle_pct = 88;
      // both zero, one side zero, extremes
      operand_backlog.push_back('{32'h0000_0000, 32'h0000_0000});
      operand_backlog.push_back('{32'h0000_0000, 32'h0000_0005});
      operand_backlog.push_back('{32'h0000_0007, 32'h0000_0000});
      operand_backlog.push_back('{32'h0000_0001, 32'h0000_0000});
      operand_backlog.push_back('{32'h0000_0000, 32'hFFFF_FFFF});
      operand_backlog.push_back('{32'hFFFF_FFFF, 32'h0000_0000});
      operand_backlog.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
      operand_backlog.push_back('{32'h0000_0001, 32'h0000_0001});
      operand_backlog.push_back('{32'h0000_0001, 32'hFFFF_FFFF});
      operand_backlog.push_back('{32'hFFFF_FFFF, 32'h0000_0001});
      // coprime neighbours at the top: largest lcm
      operand_backlog.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFE});
      operand_backlog.push_back('{32'd12, 32'd18});
      operand_backlog.push_back('{32'd18, 32'd12});
      operand_backlog.push_back('{32'd6, 32'd6});
      // two large primes
      operand_backlog.push_back('{32'd4294967291, 32'd4294967279});
      // consecutive fibonacci numbers: longest euclid chain, both orders
      operand_backlog.push_back('{32'd2971215073, 32'd1836311903});
      operand_backlog.push_back('{32'd1836311903, 32'd2971215073});
      // top bit alone and alternating bit patterns
      operand_backlog.push_back('{32'h8000_0000, 32'h8000_0000});
      operand_backlog.push_back('{32'h8000_0000, 32'h4000_0000});
      operand_backlog.push_back('{32'hAAAA_AAAA, 32'h5555_5555});
      operand_backlog.push_back('{32'h5555_5555, 32'hAAAA_AAAA});
      operand_backlog.push_back('{32'h0001_0000, 32'h0000_FFFF});
      wait_drained();

      // random, receiver mostly stalling, opened by a long hold-off
      hold_requests++;
      queue_random(125);
      wait_drained();

      // random, sender mostly idle
      send_idle_pct = 88;
      recv_idle_pct = 25;
      queue_random(125);
      wait_drained();

      // random, no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(100);
      wait_drained();

      // let any stray response show up
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("gcd_lcm_unit_top_test: done, clean");
      end else begin
         $display("gcd_lcm_unit_top_test: done, errors");
      end
      $finish;
   end

endmodule
